### rtl/bsps2_pkg.sv
// Shared types and constants of the cumulative cubic B-spline pose blender.
// Holds the controller-to-datapath command and status structs and the term order table.
// No dependencies.
`default_nettype none

package bsps2_pkg;

	localparam int NUM_TERMS = 9;
	localparam int CNT_W     = 5;

	localparam logic [CNT_W-1:0] DIV_LAST       = CNT_W'(3);
	localparam logic [CNT_W-1:0] TERM_ISSUE_END = CNT_W'(2 * NUM_TERMS);
	localparam logic [CNT_W-1:0] TERM_LAST      = CNT_W'(2 * NUM_TERMS + 1);
	localparam logic [CNT_W-1:0] TERM_ACC_FIRST = CNT_W'(3);

	typedef enum logic [2:0] {
		MUL_TT  = 3'd0,
		MUL_T2T = 3'd1,
		MUL_DIV = 3'd2,
		MUL_LO  = 3'd3,
		MUL_HI  = 3'd4
	} mul_op_t;

	typedef enum logic [2:0] {
		CONS_NONE = 3'd0,
		CONS_T2   = 3'd1,
		CONS_T3   = 3'd2,
		CONS_BETA = 3'd3,
		CONS_LO   = 3'd4,
		CONS_HI   = 3'd5
	} cons_op_t;

	typedef enum logic [1:0] {
		CH_X = 2'd0,
		CH_Y = 2'd1,
		CH_H = 2'd2
	} chan_t;

	typedef struct packed {
		logic     start;
		logic     push;
		mul_op_t  mul_op;
		logic [1:0] mul_beta;
		chan_t    mul_chan;
		cons_op_t cons_op;
		logic [1:0] cons_beta;
		logic     acc_en;
		chan_t    acc_chan;
		logic     out_load;
		logic     out_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
	} dp_stat_t;

	typedef struct packed {
		logic [1:0] beta;
		chan_t      chan;
	} term_sel_t;

	// term j blends difference beta of channel chan, j = 3 * beta + chan
	function automatic term_sel_t term_sel(input logic [3:0] j);
		term_sel_t s;
		case (j)
			4'd0: s = '{beta: 2'd0, chan: CH_X};
			4'd1: s = '{beta: 2'd0, chan: CH_Y};
			4'd2: s = '{beta: 2'd0, chan: CH_H};
			4'd3: s = '{beta: 2'd1, chan: CH_X};
			4'd4: s = '{beta: 2'd1, chan: CH_Y};
			4'd5: s = '{beta: 2'd1, chan: CH_H};
			4'd6: s = '{beta: 2'd2, chan: CH_X};
			4'd7: s = '{beta: 2'd2, chan: CH_Y};
			4'd8: s = '{beta: 2'd2, chan: CH_H};
			default: s = '{beta: 2'd0, chan: CH_X};
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/bsps2_ctrl.sv
// Sequencer of the B-spline pose blender: handshakes and per-cycle datapath commands.
// Depends on bsps2_pkg.
`default_nettype none

module bsps2_ctrl
	import bsps2_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     operation,
	input  wire logic     out_stall,
	input  wire dp_stat_t stat,
	output logic          in_stall,
	output logic          out_valid,
	output dp_cmd_t       cmd
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_T2   = 9'b000000010,
		S_T2W  = 9'b000000100,
		S_T3   = 9'b000001000,
		S_T3W  = 9'b000010000,
		S_DIV  = 9'b000100000,
		S_TERM = 9'b001000000,
		S_OUT  = 9'b010000000,
		S_ZERO = 9'b100000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] cnt_m1, cnt_m3;
	logic             out_valid_q;
	logic             out_free;
	term_sel_t        ti, tc;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cnt_d    = cnt_q;
		out_free = !out_valid_q || !out_stall;
		cnt_m1   = cnt_q - CNT_W'(1);
		cnt_m3   = cnt_q - TERM_ACC_FIRST;
		ti       = term_sel(cnt_q[CNT_W-1:1]);
		tc       = term_sel(cnt_m3[CNT_W-1:1]);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!operation) begin
						cmd.push = 1'b1;
					end else if (stat.full) begin
						cmd.start = 1'b1;
						state_d   = S_T2;
					end else begin
						state_d = S_ZERO;
					end
				end
			end
			S_T2: begin
				cmd.mul_op = MUL_TT;
				state_d    = S_T2W;
			end
			S_T2W: begin
				cmd.cons_op = CONS_T2;
				state_d     = S_T3;
			end
			S_T3: begin
				cmd.mul_op = MUL_T2T;
				state_d    = S_T3W;
			end
			S_T3W: begin
				cmd.cons_op = CONS_T3;
				state_d     = S_DIV;
				cnt_d       = '0;
			end
			S_DIV: begin
				if (cnt_q != DIV_LAST) begin
					cmd.mul_op   = MUL_DIV;
					cmd.mul_beta = cnt_q[1:0];
				end
				if (cnt_q != '0) begin
					cmd.cons_op   = CONS_BETA;
					cmd.cons_beta = cnt_m1[1:0];
				end
				if (cnt_q == DIV_LAST) begin
					state_d = S_TERM;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_TERM: begin
				if (cnt_q < TERM_ISSUE_END) begin
					cmd.mul_op   = cnt_q[0] ? MUL_HI : MUL_LO;
					cmd.mul_beta = ti.beta;
					cmd.mul_chan = ti.chan;
				end
				if ((cnt_q != '0) && (cnt_q <= TERM_ISSUE_END)) begin
					cmd.cons_op = cnt_m1[0] ? CONS_HI : CONS_LO;
				end
				if ((cnt_q >= TERM_ACC_FIRST) && cnt_q[0]) begin
					cmd.acc_en   = 1'b1;
					cmd.acc_chan = tc.chan;
				end
				if (cnt_q == TERM_LAST) begin
					state_d = S_OUT;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_ZERO: begin
				if (out_free) begin
					cmd.out_zero = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= (cmd.out_load || cmd.out_zero) || (out_valid_q && out_stall);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/bsps2_dp.sv
// Datapath of the B-spline pose blender: pose window, shared multiplier, basis,
// rounding accumulators and result register. Depends on bsps2_pkg.
`default_nettype none

module bsps2_dp
	import bsps2_pkg::*;
#(
	parameter int POS_WIDTH      = 32,
	parameter int ANGLE_WIDTH    = 16,
	parameter int TIME_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dp_cmd_t                       cmd,
	input  wire logic signed [POS_WIDTH-1:0]   pose_x,
	input  wire logic signed [POS_WIDTH-1:0]   pose_y,
	input  wire logic        [ANGLE_WIDTH-1:0] pose_heading,
	input  wire logic        [TIME_FRAC_BITS:0] spline_time,
	output dp_stat_t                           stat,
	output logic signed [POS_WIDTH-1:0]        res_x,
	output logic signed [POS_WIDTH-1:0]        res_y,
	output logic        [ANGLE_WIDTH-1:0]      res_heading,
	output logic                               res_ready
);

	localparam int F      = TIME_FRAC_BITS;
	localparam int PW     = POS_WIDTH;
	localparam int AW     = ANGLE_WIDTH;
	localparam int DW     = (PW + 1 > AW) ? PW + 1 : AW;
	localparam int LO_W   = DW / 2;
	localparam int MA     = F + 5;
	localparam int MB     = (LO_W + 1 > F + 5) ? LO_W + 1 : F + 5;
	localparam int PROD_W = MA + MB;
	localparam int SUM_W  = F + DW + 2;
	localparam int ACC_W  = DW + 2;
	localparam int NW     = F + 3;
	localparam int NXW    = F + 5;
	localparam int DIV_S  = F + 6;

	localparam logic [MA-1:0]           DIV_M  = MA'((64'd1 << DIV_S) / 64'd6);
	localparam logic [F:0]              ONE_T  = {1'b1, {F{1'b0}}};
	localparam logic [PROD_W-1:0]       P_HALF = {{(PROD_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] S_HALF = {{(SUM_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

	logic signed [PW-1:0] win_x_q [4];
	logic signed [PW-1:0] win_y_q [4];
	logic [AW-1:0]        win_h_q [4];
	logic signed [DW-1:0] diff_x_q [3];
	logic signed [DW-1:0] diff_y_q [3];
	logic signed [DW-1:0] diff_h_q [3];
	logic [2:0]           loaded_q;

	logic [F:0]              t_q, t2_q, t3_q;
	logic [F:0]              beta_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0] psum_q, sum_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_h_q;
	logic signed [PW-1:0]    out_x_q, out_y_q;
	logic [AW-1:0]           out_h_q;
	logic                    out_ready_q;

	logic signed [MA-1:0]    mul_a;
	logic signed [MB-1:0]    mul_b;
	logic signed [DW-1:0]    d_sel;
	logic [NXW-1:0]          te, t2e, t3e, n1x, n2x, n3x;
	logic [NW-1:0]           numer [3];
	logic [NW-1:0]           n_cons, q6, rem;
	logic [F:0]              q_est;
	logic [PROD_W-1:0]       prod_rnd;
	logic signed [SUM_W-1:0] sum_rnd;
	logic signed [ACC_W-1:0] term;
	logic signed [PW:0]      dx_new, dy_new;
	logic [AW-1:0]           dh_new;

	function automatic logic signed [PW-1:0] sat_pos(input logic signed [ACC_W-1:0] a);
		logic signed [PW-1:0] r;
		if ((a[ACC_W-1:PW-1] == '0) || (a[ACC_W-1:PW-1] == '1)) begin
			r = a[PW-1:0];
		end else if (a[ACC_W-1]) begin
			r = {1'b1, {(PW-1){1'b0}}};
		end else begin
			r = {1'b0, {(PW-1){1'b1}}};
		end
		return r;
	endfunction

	// basis numerators, kept modulo 2^NXW; final values are non-negative
	always_comb begin
		te    = NXW'(t_q);
		t2e   = NXW'(t2_q);
		t3e   = NXW'(t3_q);
		n1x   = (NXW'(5) << F) + (te << 1) + te - (t2e << 1) - t2e + t3e + NXW'(3);
		n2x   = (NXW'(1) << F) + (te << 1) + te + (t2e << 1) + t2e - (t3e << 1) + NXW'(3);
		n3x   = t3e + NXW'(3);
		numer[0] = n1x[NW-1:0];
		numer[1] = n2x[NW-1:0];
		numer[2] = n3x[NW-1:0];
	end

	always_comb begin
		case (cmd.mul_chan)
			CH_X:    d_sel = diff_x_q[cmd.mul_beta];
			CH_Y:    d_sel = diff_y_q[cmd.mul_beta];
			default: d_sel = diff_h_q[cmd.mul_beta];
		endcase
	end

	always_comb begin
		unique case (cmd.mul_op)
			MUL_TT: begin
				mul_a = MA'(t_q);
				mul_b = MB'(t_q);
			end
			MUL_T2T: begin
				mul_a = MA'(t2_q);
				mul_b = MB'(t_q);
			end
			MUL_DIV: begin
				mul_a = DIV_M;
				mul_b = MB'(numer[cmd.mul_beta]);
			end
			MUL_LO: begin
				mul_a = MA'(beta_q[cmd.mul_beta]);
				mul_b = MB'(d_sel[LO_W-1:0]);
			end
			MUL_HI: begin
				mul_a = MA'(beta_q[cmd.mul_beta]);
				mul_b = MB'($signed(d_sel[DW-1:LO_W]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// division by six: reciprocal estimate, then one correction step
	always_comb begin
		prod_rnd = prod_q + P_HALF;
		q_est    = prod_q[DIV_S+F:DIV_S];
		n_cons   = numer[cmd.cons_beta];
		q6       = NW'({q_est, 2'b00}) + NW'({q_est, 1'b0});
		rem      = n_cons - q6;
		sum_rnd  = sum_q + S_HALF;
		term     = sum_rnd[SUM_W-1:F];
		dx_new   = $signed({pose_x[PW-1], pose_x}) - $signed({win_x_q[3][PW-1], win_x_q[3]});
		dy_new   = $signed({pose_y[PW-1], pose_y}) - $signed({win_y_q[3][PW-1], win_y_q[3]});
		dh_new   = pose_heading - win_h_q[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (cmd.push && !loaded_q[2]) begin
			loaded_q <= loaded_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.push) begin
			for (int k = 0; k < 3; k++) begin
				win_x_q[k] <= win_x_q[k+1];
				win_y_q[k] <= win_y_q[k+1];
				win_h_q[k] <= win_h_q[k+1];
			end
			win_x_q[3] <= pose_x;
			win_y_q[3] <= pose_y;
			win_h_q[3] <= pose_heading;
			for (int k = 0; k < 2; k++) begin
				diff_x_q[k] <= diff_x_q[k+1];
				diff_y_q[k] <= diff_y_q[k+1];
				diff_h_q[k] <= diff_h_q[k+1];
			end
			diff_x_q[2] <= DW'(dx_new);
			diff_y_q[2] <= DW'(dy_new);
			diff_h_q[2] <= DW'($signed(dh_new));
		end
		if (cmd.start) begin
			if (spline_time[F] && (spline_time[F-1:0] != '0)) begin
				t_q <= ONE_T;
			end else begin
				t_q <= spline_time;
			end
		end
		case (cmd.cons_op)
			CONS_T2:   t2_q <= prod_rnd[2*F:F];
			CONS_T3:   t3_q <= prod_rnd[2*F:F];
			CONS_BETA: beta_q[cmd.cons_beta] <= q_est + (F+1)'(rem >= NW'(6));
			CONS_LO:   psum_q <= SUM_W'(prod_q);
			CONS_HI:   sum_q <= psum_q + (SUM_W'(prod_q) <<< LO_W);
			default: begin
			end
		endcase
		if (cmd.start) begin
			acc_x_q <= ACC_W'(win_x_q[0]);
			acc_y_q <= ACC_W'(win_y_q[0]);
			acc_h_q <= ACC_W'(win_h_q[0]);
		end else if (cmd.acc_en) begin
			case (cmd.acc_chan)
				CH_X:    acc_x_q <= acc_x_q + term;
				CH_Y:    acc_y_q <= acc_y_q + term;
				default: acc_h_q <= acc_h_q + term;
			endcase
		end
		if (cmd.out_load) begin
			out_x_q     <= sat_pos(acc_x_q);
			out_y_q     <= sat_pos(acc_y_q);
			out_h_q     <= acc_h_q[AW-1:0];
			out_ready_q <= 1'b1;
		end else if (cmd.out_zero) begin
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_h_q     <= '0;
			out_ready_q <= 1'b0;
		end
	end

	assign stat.full   = loaded_q[2];
	assign res_x       = out_x_q;
	assign res_y       = out_y_q;
	assign res_heading = out_h_q;
	assign res_ready   = out_ready_q;

endmodule

`default_nettype wire

### rtl/bspline_pose2_split_interp.sv
// Top level of the cumulative cubic B-spline pose blender (heading and position split).
// Depends on bsps2_pkg, bsps2_ctrl and bsps2_dp.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  operation, pose_x, pose_y, pose_heading, spline_time
//  out      out_valid / out_stall out_x, out_y, out_heading, window_ready
//
// A push transfer gives no result and leaves in_stall low.
// An evaluate transfer with a full window holds in_stall high until its result is loaded:
// 23 products on one shared multiplier, a low-half and a high-half product per rounded blend term.
// An evaluate transfer before four pushes returns zeros.
// Reset clears the pose count and handshake state; in_stall is high while a blend runs
// and while its result waits for the output register to free up.
`default_nettype none

module bspline_pose2_split_interp
	import bsps2_pkg::*;
#(
	parameter int POS_WIDTH      = 32,
	parameter int ANGLE_WIDTH    = 16,
	parameter int TIME_FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           operation,
	input  wire logic signed [POS_WIDTH-1:0]    pose_x,
	input  wire logic signed [POS_WIDTH-1:0]    pose_y,
	input  wire logic        [ANGLE_WIDTH-1:0]  pose_heading,
	input  wire logic        [TIME_FRAC_BITS:0] spline_time,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [POS_WIDTH-1:0]         out_x,
	output logic signed [POS_WIDTH-1:0]         out_y,
	output logic        [ANGLE_WIDTH-1:0]       out_heading,
	output logic                                window_ready
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bsps2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	bsps2_dp #(
		.POS_WIDTH      (POS_WIDTH),
		.ANGLE_WIDTH    (ANGLE_WIDTH),
		.TIME_FRAC_BITS (TIME_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.spline_time  (spline_time),
		.stat         (stat),
		.res_x        (out_x),
		.res_y        (out_y),
		.res_heading  (out_heading),
		.res_ready    (window_ready)
	);

endmodule

`default_nettype wire

### sim/bspline_pose2_split_interp_test.sv
// Self-checking testbench for bspline_pose2_split_interp: pushes control poses and evaluates
// the cubic B-spline blend with random idling on both channels, checking every result transfer.
// Depends only on rtl/bspline_pose2_split_interp.sv and its submodules.
`default_nettype none

module bspline_pose2_split_interp_test;

	localparam int POS_W = 32;
	localparam int ANG_W = 16;
	localparam int TFRAC = 16;
	localparam longint T_ONE = 64'sd65536;
	localparam longint T_HALF = 64'sd32768;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -POS_MAX - 1;
	localparam logic [TFRAC:0] T_TOP = 17'h1FFFF;
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_EVAL = 1'b1;
	localparam int RANDOM_ITEMS = 1130;
	localparam int HOLD_AT = 350;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic                    operation;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [ANG_W-1:0]        heading;
		logic [TFRAC:0]          stime;
	} pose_cmd_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [ANG_W-1:0]        heading;
		logic                    ready;
	} blend_t;

	class spline_blend_board;
		longint win_x[4];
		longint win_y[4];
		logic [ANG_W-1:0] win_h[4];
		int unsigned loaded;
		blend_t pending_blends[$];
		int unsigned mismatches;

		function new();
			for (int k = 0; k < 4; k++) begin
				win_x[k] = 0;
				win_y[k] = 0;
				win_h[k] = '0;
			end
			loaded = 0;
			mismatches = 0;
		endfunction

		function longint scale_diff(longint beta, longint d);
			longint hi;
			longint lo;
			hi = d >>> TFRAC;
			lo = d - hi * T_ONE;
			return beta * hi + ((beta * lo + T_HALF) >>> TFRAC);
		endfunction

		function logic signed [POS_W-1:0] blend_axis(longint p[4], longint b[3]);
			longint acc;
			acc = p[0];
			for (int k = 1; k < 4; k++)
				acc += scale_diff(b[k-1], p[k] - p[k-1]);
			if (acc > POS_MAX)
				acc = POS_MAX;
			if (acc < POS_MIN)
				acc = POS_MIN;
			return POS_W'(acc);
		endfunction

		function logic [ANG_W-1:0] blend_heading(longint b[3]);
			longint acc;
			longint d;
			logic [ANG_W-1:0] dh;
			acc = win_h[0];
			for (int k = 1; k < 4; k++) begin
				dh = win_h[k] - win_h[k-1];
				d = longint'($signed(dh));
				acc += (b[k-1] * d + T_HALF) >>> TFRAC;
			end
			return ANG_W'(acc);
		endfunction

		function void take_command(pose_cmd_t c);
			longint t;
			longint t2;
			longint t3;
			longint b[3];
			blend_t r;
			if (c.operation == OP_PUSH) begin
				for (int k = 0; k < 3; k++) begin
					win_x[k] = win_x[k+1];
					win_y[k] = win_y[k+1];
					win_h[k] = win_h[k+1];
				end
				win_x[3] = longint'(c.x);
				win_y[3] = longint'(c.y);
				win_h[3] = c.heading;
				if (loaded < 4)
					loaded++;
				return;
			end
			r = '0;
			if (loaded == 4) begin
				t = longint'(c.stime);
				if (t > T_ONE)
					t = T_ONE;
				t2 = (t * t + T_HALF) >>> TFRAC;
				t3 = (t2 * t + T_HALF) >>> TFRAC;
				b[0] = (5 * T_ONE + 3 * t - 3 * t2 + t3 + 3) / 6;
				b[1] = (T_ONE + 3 * t + 3 * t2 - 2 * t3 + 3) / 6;
				b[2] = (t3 + 3) / 6;
				r.x = blend_axis(win_x, b);
				r.y = blend_axis(win_y, b);
				r.heading = blend_heading(b);
				r.ready = 1'b1;
			end
			pending_blends.push_back(r);
		endfunction

		function void check_blend(blend_t got);
			blend_t want;
			if (pending_blends.size() == 0) begin
				$error("unexpected result transfer: x %0d y %0d heading %0d ready %0b",
					got.x, got.y, got.heading, got.ready);
				mismatches++;
				return;
			end
			want = pending_blends.pop_front();
			if (got.x !== want.x) begin
				$error("out_x: expected %0d, got %0d", want.x, got.x);
				mismatches++;
			end
			if (got.y !== want.y) begin
				$error("out_y: expected %0d, got %0d", want.y, got.y);
				mismatches++;
			end
			if (got.heading !== want.heading) begin
				$error("out_heading: expected %0d, got %0d", want.heading, got.heading);
				mismatches++;
			end
			if (got.ready !== want.ready) begin
				$error("window_ready: expected %0b, got %0b", want.ready, got.ready);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_PUSH;
	logic signed [POS_W-1:0] pose_x = '0;
	logic signed [POS_W-1:0] pose_y = '0;
	logic [ANG_W-1:0] pose_heading = '0;
	logic [TFRAC:0] spline_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] out_x;
	logic signed [POS_W-1:0] out_y;
	logic [ANG_W-1:0] out_heading;
	logic window_ready;

	spline_blend_board board;
	int unsigned gap_pct = 20;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	bspline_pose2_split_interp i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.spline_time  (spline_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_heading  (out_heading),
		.window_ready (window_ready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_cmd(logic op, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
		logic [ANG_W-1:0] h, logic [TFRAC:0] t);
		pose_cmd_t c;
		c = '{operation: op, x: x, y: y, heading: h, stime: t};
		if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= c.operation;
		pose_x <= c.x;
		pose_y <= c.y;
		pose_heading <= c.heading;
		spline_time <= c.stime;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.take_command(c);
	endtask

	// result transfers
	always @(posedge clk) begin
		blend_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{x: out_x, y: out_y, heading: out_heading, ready: window_ready};
			board.check_blend(got);
		end
	end

	// receiver idling, plus one long hold-off to back the block up
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin
		#2_400_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic op;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [TFRAC:0] t;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window not full
		send_cmd(OP_EVAL, $urandom, $urandom, 16'($urandom), '0);
		send_cmd(OP_EVAL, $urandom, $urandom, 16'($urandom), T_TOP);
		send_cmd(OP_PUSH, 32'sd65536000, -32'sd327680, 16'h0000, T_TOP);
		send_cmd(OP_PUSH, 32'sd65536100, -32'sd300000, 16'h4000, '0);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd32768);
		send_cmd(OP_PUSH, -32'sd123456, 32'sd777777, 16'hC000, 17'd5);
		send_cmd(OP_PUSH, 32'sd42, 32'sd99999, 16'hFF00, 17'd65536);
		// full window, time extremes and above one
		send_cmd(OP_EVAL, '0, '0, '0, 17'd0);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd1);
		send_cmd(OP_EVAL, $urandom, $urandom, 16'($urandom), 17'd32768);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd65535);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd65536);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd65537);
		send_cmd(OP_EVAL, '0, '0, '0, T_TOP);
		// position and heading extremes
		send_cmd(OP_PUSH, 32'sh7FFFFFFF, -32'sh80000000, 16'hFFFF, T_TOP);
		send_cmd(OP_PUSH, -32'sh80000000, 32'sh7FFFFFFF, 16'h8000, '0);
		send_cmd(OP_PUSH, 32'sh7FFFFFFF, -32'sh80000000, 16'h7FFF, 17'd65537);
		send_cmd(OP_PUSH, -32'sh80000000, 32'sh7FFFFFFF, 16'h0001, T_TOP);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd0);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd21845);
		send_cmd(OP_EVAL, 32'sh7FFFFFFF, -32'sh80000000, 16'hFFFF, 17'd65536);
		send_cmd(OP_EVAL, '0, '0, '0, 17'd98304);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 35;
				endcase
			end
			if (n == HOLD_AT)
				hold_req = 1'b1;
			quiet = (n >= RANDOM_ITEMS - 150);
			op = ($urandom_range(0, 9) < 4) ? OP_PUSH : OP_EVAL;
			if (n >= HOLD_AT && n < HOLD_AT + 20)
				op = OP_EVAL;
			x = $urandom;
			y = $urandom;
			if ($urandom_range(0, 3) != 0) begin
				x = x >>> 11;
				y = y >>> 11;
			end
			case ($urandom_range(0, 7))
				0: t = '0;
				1: t = 17'd65536;
				2: t = 17'($urandom_range(65537, 131071));
				default: t = 17'($urandom_range(0, 65536));
			endcase
			send_cmd(op, x, y, 16'($urandom), t);
		end
		in_valid <= 1'b0;

		while (board.pending_blends.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
